>>> hdl/multilevel_feedback_scheduler_defines.svh
// Assertion macros for the multilevel feedback scheduler.
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define MFS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define MFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/mfs_pkg.sv
// Types, codes and defaults shared by the scheduler modules.
`timescale 1ns / 1ps
package mfs_pkg;

  localparam int MFS_LEVEL_COUNT = 4;
  localparam int MFS_QUEUE_DEPTH = 16;
  localparam int ID_W = 8;

  localparam logic [1:0] ACT_ARRIVE = 2'd0;
  localparam logic [1:0] ACT_TICK   = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  localparam logic [1:0] OP_NONE         = 2'd0;
  localparam logic [1:0] OP_PUSH         = 2'd1;
  localparam logic [1:0] OP_REMOVE_HEAD  = 2'd2;
  localparam logic [1:0] OP_REMOVE_MATCH = 2'd3;

  typedef struct packed {
    logic [1:0]      action;
    logic [ID_W-1:0] task_id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] run_task;
    logic            idle;
    logic            overflow;
  } rsp_t;

  typedef struct packed {
    logic [1:0]      op;
    logic [ID_W-1:0] id;
  } lvl_ctl_t;

  typedef struct packed {
    logic [ID_W-1:0] head;
    logic            empty;
    logic            full;
  } lvl_stat_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

>>> hdl/mfs_cell.sv
// One queue slot: holds an id, shifts from its neighbour or loads a new id.
`timescale 1ns / 1ps
module mfs_cell import mfs_pkg::*; (
  input  logic            clk,
  input  cell_ctl_t       ctl,
  input  logic [ID_W-1:0] next_id,
  input  logic [ID_W-1:0] load_id,
  input  logic [ID_W-1:0] key,
  output logic [ID_W-1:0] data,
  output logic            hit
);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      data <= next_id;
    end else if (ctl.load) begin
      data <= load_id;
    end
  end

  assign hit = (data == key);

endmodule

>>> hdl/mfs_level.sv
// One priority level: a shift chain of slots with its fill count.
`timescale 1ns / 1ps
module mfs_level import mfs_pkg::*; #(
  parameter int QUEUE_DEPTH = MFS_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  lvl_ctl_t  ctl,
  output lvl_stat_t stat
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0]          count, count_next;
  logic [ID_W-1:0]        data [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] hit, live, match, first, rm;
  logic                   found, full, empty;
  cell_ctl_t              cctl [QUEUE_DEPTH];

  assign full  = (count == CW'(QUEUE_DEPTH));
  assign empty = (count == '0);

  // first matching live slot, then every slot from there on closes up
  assign match = hit & live;
  assign found = |match;
  assign first = match & (~match + 1'b1);

  always_comb begin
    case (ctl.op)
      OP_REMOVE_HEAD:  rm = empty ? '0 : '1;
      OP_REMOVE_MATCH: rm = ~(first - 1'b1);
      default:         rm = '0;
    endcase
  end

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_slot
    logic [ID_W-1:0] nbr;
    if (k == QUEUE_DEPTH - 1) begin : g_last
      assign nbr = data[k];
    end else begin : g_mid
      assign nbr = data[k+1];
    end
    assign live[k]       = (CW'(k) < count);
    assign cctl[k].shift = rm[k];
    assign cctl[k].load  = (ctl.op == OP_PUSH) && (CW'(k) == count);

    mfs_cell u_cell (
      .clk     (clk),
      .ctl     (cctl[k]),
      .next_id (nbr),
      .load_id (ctl.id),
      .key     (ctl.id),
      .data    (data[k]),
      .hit     (hit[k])
    );
  end

  always_comb begin
    count_next = count;
    case (ctl.op)
      OP_PUSH:         if (!full)  count_next = count + 1'b1;
      OP_REMOVE_HEAD:  if (!empty) count_next = count - 1'b1;
      OP_REMOVE_MATCH: if (found)  count_next = count - 1'b1;
      default:         count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign stat.head  = data[0];
  assign stat.empty = empty;
  assign stat.full  = full;

endmodule

>>> hdl/multilevel_feedback_scheduler.sv
// Multilevel feedback scheduler: an item is accepted, the levels are updated in the next
// cycle and the result is registered in the report state that follows, once the result
// register is free. An item passes the update state over the shift chains, then the
// progress and report state; the next item is accepted in the report cycle when the
// result register is free. Each level is a chain of slots that shift towards the head, so
// removal by id and demotion complete in the update cycle. Reset is synchronous.
`timescale 1ns / 1ps
module multilevel_feedback_scheduler import mfs_pkg::*; #(
  parameter int LEVEL_COUNT = MFS_LEVEL_COUNT,
  parameter int QUEUE_DEPTH = MFS_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  `include "multilevel_feedback_scheduler_defines.svh"

  localparam int PW = LEVEL_COUNT + 2;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_REPORT = 2'd2;

  logic [1:0]       fsm, fsm_next;
  req_t             cmd;
  logic             ovf, ovf_next;
  logic             req_acc, out_free;
  logic             report_go, rsp_sane;
  lvl_ctl_t         ctl  [LEVEL_COUNT];
  lvl_stat_t        stat [LEVEL_COUNT];
  logic [PW-1:0]    progress [LEVEL_COUNT];
  logic [PW-1:0]    progress_next [LEVEL_COUNT];
  logic [PW-1:0]    masked [LEVEL_COUNT];
  logic [LEVEL_COUNT-1:0] bsel, fsel, scanned, push_vec;
  logic             have_b, any_busy, tgt_full;
  logic [ID_W-1:0]  head_b, head_f;

  for (genvar i = 0; i < LEVEL_COUNT; i++) begin : g_lvl
    mfs_level #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_level (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl[i]),
      .stat (stat[i])
    );
    assign masked[i]   = progress[i] & ((PW'(1) << (i + 2)) - PW'(1));
    assign push_vec[i] = (ctl[i].op == OP_PUSH);
  end

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = !((fsm == S_IDLE) || ((fsm == S_REPORT) && out_free));
  assign req_acc   = req_valid && !req_stall;
  assign report_go = (fsm == S_REPORT) && out_free;
  assign rsp_sane  = !rsp.idle || (rsp.run_task == '0);

  // demotion source: first non-empty level, not the last, whose counter is zero
  always_comb begin
    logic seen;
    seen    = 1'b0;
    bsel    = '0;
    scanned = '0;
    for (int i = 0; i < LEVEL_COUNT; i++) begin
      scanned[i] = !seen;
      if (!seen && !stat[i].empty && (masked[i] == '0) && (i < LEVEL_COUNT - 1)) begin
        bsel[i] = 1'b1;
        seen    = 1'b1;
      end
    end
    have_b = seen;
  end

  // first busy level
  always_comb begin
    logic seen;
    seen = 1'b0;
    fsel = '0;
    for (int i = 0; i < LEVEL_COUNT; i++) begin
      if (!seen && !stat[i].empty) begin
        fsel[i] = 1'b1;
        seen    = 1'b1;
      end
    end
    any_busy = seen;
  end

  always_comb begin
    tgt_full = 1'b0;
    head_b   = '0;
    head_f   = '0;
    for (int i = 0; i < LEVEL_COUNT; i++) begin
      if (bsel[i]) head_b = stat[i].head;
      if (fsel[i]) head_f = stat[i].head;
    end
    for (int i = 0; i < LEVEL_COUNT - 1; i++) begin
      if (bsel[i] && stat[i+1].full) tgt_full = 1'b1;
    end
  end

  // level commands, issued in the update cycle only
  always_comb begin
    ovf_next = ovf;
    for (int i = 0; i < LEVEL_COUNT; i++) begin
      ctl[i].op = OP_NONE;
      ctl[i].id = cmd.task_id;
    end
    if (fsm == S_EXEC) begin
      ovf_next = 1'b0;
      case (cmd.action)
        ACT_ARRIVE: begin
          if (stat[0].full) begin
            ovf_next = 1'b1;
          end else begin
            ctl[0].op = OP_PUSH;
          end
        end
        ACT_TICK: begin
          if (have_b && tgt_full) begin
            ovf_next = 1'b1;
          end else if (have_b) begin
            for (int i = 0; i < LEVEL_COUNT; i++) begin
              if (bsel[i]) ctl[i].op = OP_REMOVE_HEAD;
            end
            for (int i = 1; i < LEVEL_COUNT; i++) begin
              if (bsel[i-1]) begin
                ctl[i].op = OP_PUSH;
                ctl[i].id = head_b;
              end
            end
          end
        end
        ACT_FINISH: begin
          for (int i = 0; i < LEVEL_COUNT; i++) begin
            if (fsel[i]) ctl[i].op = OP_REMOVE_MATCH;
          end
        end
        default: ovf_next = 1'b0;
      endcase
    end
  end

  // progress: masked or cleared during a tick's scan, cleared on a finish, bumped in the report cycle
  always_comb begin
    for (int i = 0; i < LEVEL_COUNT; i++) begin
      progress_next[i] = progress[i];
      if (fsm == S_EXEC) begin
        if ((cmd.action == ACT_TICK) && scanned[i]) begin
          progress_next[i] = stat[i].empty ? '0 : masked[i];
        end else if ((cmd.action == ACT_FINISH) && fsel[i]) begin
          progress_next[i] = '0;
        end
      end else if ((fsm == S_REPORT) && out_free && (cmd.action == ACT_TICK) && fsel[i]) begin
        progress_next[i] = progress[i] + 1'b1;
      end
    end
  end

  always_comb begin
    fsm_next = fsm;
    unique case (fsm)
      S_IDLE:   if (req_acc) fsm_next = S_EXEC;
      S_EXEC:   fsm_next = S_REPORT;
      S_REPORT: if (out_free) fsm_next = req_acc ? S_EXEC : S_IDLE;
      default:  fsm_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= S_IDLE;
      rsp_valid <= 1'b0;
      ovf       <= 1'b0;
      for (int i = 0; i < LEVEL_COUNT; i++) begin
        progress[i] <= '0;
      end
    end else begin
      fsm      <= fsm_next;
      ovf      <= ovf_next;
      progress <= progress_next;
      if ((fsm == S_REPORT) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      cmd <= req;
    end
    if ((fsm == S_REPORT) && out_free) begin
      rsp.run_task <= any_busy ? head_f : '0;
      rsp.idle     <= !any_busy;
      rsp.overflow <= ovf;
    end
  end

  `MFS_ASSERT_ALWAYS(a_one_push, $countones(push_vec) <= 1, "more than one level pushed")
  `MFS_ASSERT_NEXT(a_acc_exec, req_acc, fsm == S_EXEC, "accepted item not in update cycle")
  `MFS_ASSERT_NEXT(a_report_load, report_go, rsp_valid && rsp_sane, "no result after report")

endmodule

>>> bench/scheduler_checker.sv
// Scoreboard for the multilevel feedback scheduler: level predictor and result comparison.
`timescale 1ns / 1ps
module scheduler_checker import mfs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   mismatches,
  output int   outstanding
);
  localparam int MAX_REPORTS = 10;
  localparam int CREDIT_W = 6;

  logic [ID_W-1:0]     level_ids [MFS_LEVEL_COUNT][MFS_QUEUE_DEPTH];
  int                  level_fill [MFS_LEVEL_COUNT];
  logic [CREDIT_W-1:0] level_credit [MFS_LEVEL_COUNT];
  rsp_t                expected_dispatch [$];
  int                  results_seen;

  function automatic int first_busy();
    for (int i = 0; i < MFS_LEVEL_COUNT; i++)
      if (level_fill[i] != 0) return i;
    return -1;
  endfunction

  function automatic bit append_id(input int lvl, input logic [ID_W-1:0] id);
    if (level_fill[lvl] >= MFS_QUEUE_DEPTH) return 1'b0;
    level_ids[lvl][level_fill[lvl]] = id;
    level_fill[lvl]++;
    return 1'b1;
  endfunction

  function automatic void drop_entry(input int lvl, input int pos);
    for (int k = pos; k + 1 < level_fill[lvl]; k++)
      level_ids[lvl][k] = level_ids[lvl][k + 1];
    level_fill[lvl]--;
  endfunction

  function automatic rsp_t schedule_step(input req_t item);
    rsp_t res;
    int   lvl;
    int   pos;
    bit   blocked;
    bit   done;
    res = '0;
    blocked = 1'b0;
    done = 1'b0;
    case (item.action)
      ACT_ARRIVE: blocked = !append_id(0, item.task_id);
      ACT_TICK: begin
        for (lvl = 0; lvl < MFS_LEVEL_COUNT && !done; lvl++) begin
          level_credit[lvl] &= (CREDIT_W'(1) << (lvl + 2)) - CREDIT_W'(1);
          if (level_fill[lvl] == 0) begin
            level_credit[lvl] = '0;
          end else if (level_credit[lvl] == '0 && lvl < MFS_LEVEL_COUNT - 1) begin
            // scan stops here even when the demotion does not fit
            done = 1'b1;
            if (append_id(lvl + 1, level_ids[lvl][0])) drop_entry(lvl, 0);
            else blocked = 1'b1;
          end
        end
        lvl = first_busy();
        if (lvl >= 0) level_credit[lvl]++;
      end
      ACT_FINISH: begin
        lvl = first_busy();
        if (lvl >= 0) begin
          for (pos = 0; pos < level_fill[lvl] && !done; pos++) begin
            if (level_ids[lvl][pos] == item.task_id) begin
              drop_entry(lvl, pos);
              done = 1'b1;
            end
          end
          level_credit[lvl] = '0;
        end
      end
      default: ;
    endcase
    lvl = first_busy();
    if (lvl < 0) begin
      res.idle = 1'b1;
      res.run_task = '0;
    end else begin
      res.idle = 1'b0;
      res.run_task = level_ids[lvl][0];
    end
    res.overflow = blocked;
    return res;
  endfunction

  task automatic log_failure(input string msg);
    if (mismatches < MAX_REPORTS) $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < MFS_LEVEL_COUNT; i++) begin
        level_fill[i] = 0;
        level_credit[i] = '0;
      end
      expected_dispatch.delete();
      mismatches = 0;
      results_seen = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_dispatch.size() == 0) begin
          log_failure($sformatf("result %0d arrived with no item waiting", results_seen));
        end else begin
          want = expected_dispatch.pop_front();
          if (rsp.run_task !== want.run_task || rsp.idle !== want.idle ||
              rsp.overflow !== want.overflow)
            log_failure($sformatf(
              "result %0d: expected run_task %0d idle %0b overflow %0b, got %0d %0b %0b",
              results_seen, want.run_task, want.idle, want.overflow,
              rsp.run_task, rsp.idle, rsp.overflow));
        end
        results_seen++;
      end
      if (req_valid && !req_stall) expected_dispatch.push_back(schedule_step(req));
    end
    outstanding = expected_dispatch.size();
  end

endmodule

>>> bench/testbench.sv
// Top of the scheduler testbench: clock, reset, item stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module testbench;
  import mfs_pkg::*;

  localparam logic [1:0] ACT_UNDEFINED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 600;
  localparam int SETTLE_CYCLES = 20;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int mismatches;
  int outstanding;
  int send_gap_pct = 0;
  int rsp_stall_pct = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  logic [ID_W-1:0] last_run = '0;
  logic last_idle = 1'b1;

  multilevel_feedback_scheduler dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  scheduler_checker scoreboard (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) rsp_stall <= ($urandom_range(99) < rsp_stall_pct);

  // last reported head, used to finish the running task
  always @(posedge clk) begin
    if (rsp_valid && !rsp_stall) begin
      last_run <= rsp.run_task;
      last_idle <= rsp.idle;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("FAIL multilevel_feedback_scheduler");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [ID_W-1:0] pick_id();
    // small pool half the time so finishes often hit a queued id
    if ($urandom_range(1) == 1) return ID_W'($urandom_range(15, 1));
    return ID_W'($urandom_range(255));
  endfunction

  task automatic send_item(input logic [1:0] act, input logic [ID_W-1:0] id);
    while ($urandom_range(99) < send_gap_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req <= '{action: act, task_id: id};
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_until_drained();
    req_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  task automatic random_segment();
    int kind;
    int n;
    kind = $urandom_range(9);
    n = (kind >= 3 && kind <= 5) ? $urandom_range(40, 1) : $urandom_range(20, 1);
    for (int k = 0; k < n; k++) begin
      case (kind)
        0, 1, 2: send_item(ACT_ARRIVE, pick_id());
        3, 4, 5: send_item(ACT_TICK, ID_W'($urandom_range(255)));
        6, 7: begin
          // finish whatever runs now, so deeper levels drain
          wait_until_drained();
          send_item(ACT_FINISH, last_idle ? pick_id() : last_run);
        end
        8: send_item(ACT_FINISH, pick_id());
        default: send_item(2'($urandom_range(ACT_UNDEFINED)), ID_W'($urandom_range(255)));
      endcase
    end
  endtask

  task automatic run_phase(input int gap_pct, input int stall_pct);
    int target;
    send_gap_pct = gap_pct;
    rsp_stall_pct = stall_pct;
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) random_segment();
    wait_until_drained();
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty scheduler: finish, undefined action and tick all report idle
    send_item(ACT_FINISH, 8'h5A);
    send_item(ACT_UNDEFINED, 8'hFF);
    send_item(ACT_TICK, 8'h00);
    // fill level 0, then one more arrival is dropped
    send_item(ACT_ARRIVE, 8'hFF);
    send_item(ACT_ARRIVE, 8'h00);
    for (int i = 1; i <= MFS_QUEUE_DEPTH - 2; i++) send_item(ACT_ARRIVE, ID_W'(i));
    send_item(ACT_ARRIVE, 8'hA5);
    // first tick demotes the head
    send_item(ACT_TICK, 8'hFF);
    send_item(ACT_FINISH, 8'hC3);
    send_item(ACT_FINISH, 8'h00);
    send_item(ACT_UNDEFINED, 8'h00);
    wait_until_drained();

    run_phase(36, 70);
    run_phase(70, 36);
    run_phase(0, 0);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS multilevel_feedback_scheduler");
    end else begin
      $display("FAIL multilevel_feedback_scheduler");
    end
    $finish;
  end

endmodule

>>> multilevel_feedback_scheduler.f
+incdir+hdl
hdl/mfs_pkg.sv
hdl/mfs_cell.sv
hdl/mfs_level.sv
hdl/multilevel_feedback_scheduler.sv
bench/scheduler_checker.sv
bench/testbench.sv
